/* design/smoothed_gain_peak_meter_unit_defines.svh */
// Assertion macros for the smoothed gain peak meter unit design file.
// SGPM_ASSERT is masked while reset is asserted; SGPM_ASSERT_RST also checks during reset.
`ifndef SMOOTHED_GAIN_PEAK_METER_UNIT_DEFINES_SVH
`define SMOOTHED_GAIN_PEAK_METER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SGPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgpm: assertion failed");
`define SGPM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sgpm: assertion failed");
`else
`define SGPM_ASSERT(lbl, prop)
`define SGPM_ASSERT_RST(lbl, prop)
`endif
`endif

/* design/sgpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sgpm_pkg;

  // Sample and fixed-point formats.
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_W      = 24;
  localparam int COEFF_W     = 24;
  localparam int GAIN_W      = 28;
  localparam int LEVEL_W     = 24;
  localparam int DB_W        = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_FALLOFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE     = 3'd4;

  localparam logic [COEFF_W-1:0] TARGET_GAIN_RST = 24'd1048576;
  localparam logic [COEFF_W-1:0] SMOOTHING_RST   = 24'd43860;
  localparam logic [COEFF_W-1:0] FALLOFF_RST     = 24'd16623400;

  // Shared multiplier geometry.
  localparam int MUL_A_W = (SAMPLE_BITS + 1 > 27) ? SAMPLE_BITS + 1 : 27;
  localparam int MUL_B_W = 30;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int RND_W   = MUL_P_W - FRAC_W;

  // Gain limits, unity in Q4.24.
  localparam logic [GAIN_W-1:0] GAIN_ONE = 28'h100_0000;

  // Silence threshold: peak * 10^6 at or below full scale.
  localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SILENT_MAX = SAMPLE_BITS'(FULL_SCALE / 1000000);

  // Log2 approximation: g = (f * (4 - f) + 1.5 * 2^-24) / 3 in Q24.
  localparam int SC_W   = $clog2(SAMPLE_BITS);
  localparam int LOG_W  = 27;
  localparam int YSUM_W = 50;
  localparam int Q_W    = YSUM_W - FRAC_W;
  localparam logic [LOG_W-1:0]  FOUR_ONE = 27'h400_0000;
  localparam logic [YSUM_W-1:0] Y_BIAS   = 50'd25165824;
  localparam logic [MUL_B_W-1:0] RECIP3  = 30'd89478486;
  localparam int RECIP3_SHIFT = 28;

  // dB scaling: dB = round(l2 * 5 / (53 * 1024)), 1/256 dB units.
  localparam int LABS_W      = SC_W + FRAC_W;
  localparam int X5_W        = LABS_W + 3;
  localparam int DB_PRESHIFT = 10;
  localparam int Q2_W        = X5_W - DB_PRESHIFT;
  localparam logic [X5_W-1:0] DB_HALF = 32'd27136;
  localparam logic [MUL_B_W-1:0] RECIP53 = 30'd2532410;
  localparam int RECIP53_SHIFT = 27;
  localparam int DBA_W = 17;
  localparam logic [DBA_W-1:0] DBA_POS_LIM = 17'd32767;
  localparam logic [DBA_W-1:0] DBA_NEG_LIM = 17'd32768;
  localparam logic signed [DB_W-1:0] DB_MAX    = 16'sh7FFF;
  localparam logic signed [DB_W-1:0] DB_MIN    = 16'sh8000;
  localparam logic signed [DB_W-1:0] SILENT_DB = -16'sd30720;
  localparam int DB_STEP = 52;

  localparam int PK_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [COEFF_W-1:0] target_gain;
    logic               gain_enable;
    logic [COEFF_W-1:0] smoothing_coeff;
    logic [COEFF_W-1:0] meter_falloff;
    logic               stereo_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                          block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          meter_update;
    logic [LEVEL_W-1:0]            meter_level;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPD,
    ST_LEFT,
    ST_RIGHT,
    ST_RFIN,
    ST_PEAK,
    ST_CHK,
    ST_NORM,
    ST_LOGSQ,
    ST_Q3,
    ST_G,
    ST_L2,
    ST_Q53,
    ST_D,
    ST_DBRES,
    ST_REPORT,
    ST_DECAY,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* design/smoothed_gain_peak_meter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Smoothed gain stage with peak meter, one stereo frame per request.
// Input channel in_valid/in_ready/in_data carries the two samples and the
// block end flag; output channel out_valid/out_ready/out_data returns the
// gained samples and the meter report. The cfg_we/cfg_index/cfg_wdata port
// writes the gain, smoothing, falloff and mode registers; the user is to
// write them only while idle, as the block itself does not enforce it.
// Sample, gain, log and dB products run through one registered multiplier
// under a sequencer. A new request is taken only once the previous one has
// finished. A block end frame adds the dB conversion, which is skipped when
// the peak is silent and otherwise takes one normalising shift per leading
// zero of the peak.
// Reset clears the gain to zero (it ramps up), the peak and the last reported
// level, and reloads the register defaults. A result waits in the output
// register while the receiver stalls; the next request is still accepted and
// processed, and it finishes only once the output register has been taken.

`include "smoothed_gain_peak_meter_unit_defines.svh"

module smoothed_gain_peak_meter_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire sgpm_pkg::in_item_t        in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output sgpm_pkg::out_item_t            out_data,
  input  wire                            cfg_we,
  input  wire [sgpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [sgpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sgpm_pkg::*;

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]             gain_r, gain_nxt;
  logic [SAMPLE_BITS-1:0]        peak_r, peak_nxt;
  logic signed [DB_W-1:0]        last_db_r, last_db_nxt;
  logic signed [SAMPLE_BITS-1:0] left_r, left_nxt;
  logic signed [SAMPLE_BITS-1:0] right_r, right_nxt;
  logic                          blk_end_r, blk_end_nxt;
  logic                          stereo_r, stereo_nxt;
  logic signed [SAMPLE_BITS-1:0] ol_r, ol_nxt;
  logic signed [SAMPLE_BITS-1:0] or_r, or_nxt;
  logic [SAMPLE_BITS-1:0]        norm_r, norm_nxt;
  logic [SC_W-1:0]               sc_r, sc_nxt;
  logic [Q_W-1:0]                q_r, q_nxt;
  logic [LABS_W-1:0]             labs_r, labs_nxt;
  logic                          neg_r, neg_nxt;
  logic [Q2_W-1:0]               q2_r, q2_nxt;
  logic signed [DB_W-1:0]        db_r, db_nxt;
  logic                          upd_r, upd_nxt;
  logic [LEVEL_W-1:0]            lvl_r, lvl_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_data_r, out_data_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic                                out_free;
  logic                                out_load;
  logic [GAIN_W-1:0]                   target;
  logic signed [GAIN_W:0]              diff;
  logic signed [RND_W-1:0]             prod_rnd;
  logic signed [RND_W:0]               gain_sum;
  logic [GAIN_W-1:0]                   gain_clamped;
  logic signed [SAMPLE_BITS-1:0]       samp_sat;
  logic [SAMPLE_BITS-1:0]              abs_src;
  logic [SAMPLE_BITS-1:0]              abs_val;
  logic [SAMPLE_BITS+FRAC_W-2:0]       norm_ext;
  logic [FRAC_W-1:0]                   frac;
  logic [LOG_W-1:0]                    frac_comp;
  logic [YSUM_W-1:0]                   y_sum;
  logic [FRAC_W-1:0]                   g_val;
  logic [X5_W-1:0]                     x5;
  logic [DBA_W-1:0]                    db_abs;
  logic signed [DB_W-1:0]              db_conv;
  logic signed [DB_W:0]                db_diff;
  logic signed [DB_W:0]                db_diff_abs;
  logic                                silent_hit;
  logic                                change_hit;
  logic [PK_W-1:0]                     peak_wide;
  logic [LEVEL_W-1:0]                  peak_sat;

  sgpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sgpm_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (mul_p)
  );

  // Gain step operands: target is unity when gain is disabled.
  assign target = cfg.gain_enable ? {cfg.target_gain, 4'b0000} : GAIN_ONE;
  assign diff   = $signed({1'b0, target}) - $signed({1'b0, gain_r});

  // Round half up at 2^-24 for the gain and sample Q24 products.
  assign prod_rnd = $signed(mul_p[MUL_P_W-1:FRAC_W])
                    + $signed({{(RND_W-1){1'b0}}, mul_p[FRAC_W-1]});

  // Gain update, kept within 0 .. 2^28-1.
  assign gain_sum = (RND_W+1)'($signed({1'b0, gain_r})) + (RND_W+1)'(prod_rnd);
  always_comb begin
    if (gain_sum[RND_W]) begin
      gain_clamped = '0;
    end else if (|gain_sum[RND_W-1:GAIN_W]) begin
      gain_clamped = '1;
    end else begin
      gain_clamped = gain_sum[GAIN_W-1:0];
    end
  end

  // Saturate the rounded sample product to the signed sample range.
  always_comb begin
    if (prod_rnd[RND_W-1:SAMPLE_BITS-1] == '0 || prod_rnd[RND_W-1:SAMPLE_BITS-1] == '1) begin
      samp_sat = prod_rnd[SAMPLE_BITS-1:0];
    end else if (prod_rnd[RND_W-1]) begin
      samp_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      samp_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // One magnitude unit serves both channels for the peak tracker.
  assign abs_src = (state_r == ST_RFIN) ? ol_r : or_r;
  assign abs_val = abs_src[SAMPLE_BITS-1] ? (~abs_src + 1'b1) : abs_src;

  // Mantissa fraction of the normalised peak, Q24.
  assign norm_ext  = {norm_r[SAMPLE_BITS-2:0], {FRAC_W{1'b0}}};
  assign frac      = norm_ext[SAMPLE_BITS+FRAC_W-2 -: FRAC_W];
  assign frac_comp = FOUR_ONE - LOG_W'(frac);

  // Parabola term: add the rounding bias, then divide by 3 * 2^24 in two steps.
  assign y_sum = mul_p[YSUM_W-1:0] + Y_BIAS;
  assign g_val = mul_p[RECIP3_SHIFT +: FRAC_W];

  // |log2| * 5 plus half the divisor, before the divide by 53 * 1024.
  assign x5 = X5_W'(labs_r) + X5_W'({labs_r, 2'b00}) + DB_HALF;

  // dB magnitude from the reciprocal product, signed and clamped.
  assign db_abs = mul_p[RECIP53_SHIFT +: DBA_W];
  always_comb begin
    if (neg_r) begin
      db_conv = (db_abs > DBA_NEG_LIM) ? DB_MIN : -$signed(db_abs[DB_W-1:0]);
    end else begin
      db_conv = (db_abs > DBA_POS_LIM) ? DB_MAX : $signed(db_abs[DB_W-1:0]);
    end
  end

  // Report decision against the last reported level.
  assign db_diff     = (DB_W+1)'(db_r) - (DB_W+1)'(last_db_r);
  assign db_diff_abs = db_diff[DB_W] ? -db_diff : db_diff;
  assign silent_hit  = (db_r == SILENT_DB) && (last_db_r != SILENT_DB);
  assign change_hit  = db_diff_abs >= DB_STEP;
  assign peak_wide   = PK_W'(peak_r);
  assign peak_sat    = (peak_wide > PK_W'(LEVEL_MAX)) ? LEVEL_MAX : peak_wide[LEVEL_W-1:0];

  assign out_free = !out_valid_r || out_ready;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_UPD;
      ST_UPD:    state_nxt = ST_LEFT;
      ST_LEFT:   state_nxt = ST_RIGHT;
      ST_RIGHT:  state_nxt = ST_RFIN;
      ST_RFIN:   state_nxt = ST_PEAK;
      ST_PEAK:   state_nxt = blk_end_r ? ST_CHK : ST_DONE;
      ST_CHK:    state_nxt = (peak_r <= SILENT_MAX) ? ST_REPORT : ST_NORM;
      ST_NORM:   if (norm_r[SAMPLE_BITS-1]) state_nxt = ST_LOGSQ;
      ST_LOGSQ:  state_nxt = ST_Q3;
      ST_Q3:     state_nxt = ST_G;
      ST_G:      state_nxt = ST_L2;
      ST_L2:     state_nxt = ST_Q53;
      ST_Q53:    state_nxt = ST_D;
      ST_D:      state_nxt = ST_DBRES;
      ST_DBRES:  state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_DECAY;
      ST_DECAY:  state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: handshake and multiplier operand selection.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mul_a    = MUL_A_W'(cfg.smoothing_coeff);
        mul_b    = MUL_B_W'(diff);
      end
      ST_LEFT: begin
        mul_a = MUL_A_W'(left_r);
        mul_b = MUL_B_W'(gain_r);
      end
      ST_RIGHT: begin
        mul_a = MUL_A_W'(right_r);
        mul_b = MUL_B_W'(gain_r);
      end
      ST_LOGSQ: begin
        mul_a = MUL_A_W'(frac);
        mul_b = MUL_B_W'(frac_comp);
      end
      ST_G: begin
        mul_a = MUL_A_W'(q_r);
        mul_b = RECIP3;
      end
      ST_D: begin
        mul_a = MUL_A_W'(q2_r);
        mul_b = RECIP53;
      end
      ST_REPORT: begin
        mul_a = MUL_A_W'(peak_r);
        mul_b = MUL_B_W'(cfg.meter_falloff);
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath register updates, one step per state.
  always_comb begin
    gain_nxt    = gain_r;
    peak_nxt    = peak_r;
    last_db_nxt = last_db_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    blk_end_nxt = blk_end_r;
    stereo_nxt  = stereo_r;
    ol_nxt      = ol_r;
    or_nxt      = or_r;
    norm_nxt    = norm_r;
    sc_nxt      = sc_r;
    q_nxt       = q_r;
    labs_nxt    = labs_r;
    neg_nxt     = neg_r;
    q2_nxt      = q2_r;
    db_nxt      = db_r;
    upd_nxt     = upd_r;
    lvl_nxt     = lvl_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          left_nxt    = in_data.sample_left;
          right_nxt   = in_data.sample_right;
          blk_end_nxt = in_data.block_end;
          stereo_nxt  = cfg.stereo_mode;
          upd_nxt     = 1'b0;
          lvl_nxt     = '0;
        end
      end
      ST_UPD: begin
        gain_nxt = gain_clamped;
      end
      ST_RIGHT: begin
        ol_nxt = samp_sat;
      end
      ST_RFIN: begin
        or_nxt = stereo_r ? samp_sat : '0;
        if (abs_val > peak_r) peak_nxt = abs_val;
      end
      ST_PEAK: begin
        if (abs_val > peak_r) peak_nxt = abs_val;
      end
      ST_CHK: begin
        db_nxt   = SILENT_DB;
        norm_nxt = peak_r;
        sc_nxt   = '0;
      end
      ST_NORM: begin
        if (!norm_r[SAMPLE_BITS-1]) begin
          norm_nxt = {norm_r[SAMPLE_BITS-2:0], 1'b0};
          sc_nxt   = sc_r + 1'b1;
        end
      end
      ST_Q3: begin
        q_nxt = y_sum[YSUM_W-1:FRAC_W];
      end
      ST_L2: begin
        neg_nxt = (sc_r != '0);
        if (sc_r == '0) begin
          labs_nxt = LABS_W'(g_val);
        end else begin
          labs_nxt = {sc_r, {FRAC_W{1'b0}}} - LABS_W'(g_val);
        end
      end
      ST_Q53: begin
        q2_nxt = x5[X5_W-1:DB_PRESHIFT];
      end
      ST_DBRES: begin
        db_nxt = db_conv;
      end
      ST_REPORT: begin
        if (silent_hit) begin
          upd_nxt     = 1'b1;
          lvl_nxt     = '0;
          last_db_nxt = db_r;
        end else if (change_hit) begin
          upd_nxt     = 1'b1;
          lvl_nxt     = peak_sat;
          last_db_nxt = db_r;
        end
      end
      ST_DECAY: begin
        peak_nxt = mul_p[FRAC_W +: SAMPLE_BITS];
      end
      default: begin
        upd_nxt = upd_r;
      end
    endcase
  end

  // Output register: holds a finished result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_left     = ol_r;
      out_data_nxt.out_right    = or_r;
      out_data_nxt.meter_update = upd_r;
      out_data_nxt.meter_level  = lvl_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= '0;
      peak_r      <= '0;
      last_db_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gain_r      <= gain_nxt;
      peak_r      <= peak_nxt;
      last_db_r   <= last_db_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    blk_end_r  <= blk_end_nxt;
    stereo_r   <= stereo_nxt;
    ol_r       <= ol_nxt;
    or_r       <= or_nxt;
    norm_r     <= norm_nxt;
    sc_r       <= sc_nxt;
    q_r        <= q_nxt;
    labs_r     <= labs_nxt;
    neg_r      <= neg_nxt;
    q2_r       <= q2_nxt;
    db_r       <= db_nxt;
    upd_r      <= upd_nxt;
    lvl_r      <= lvl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A request holds the sequencer busy for at least the following cycle.
  `SGPM_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
  // A result only appears from the final step of the sequence.
  `SGPM_ASSERT(a_load_from_done, $rose(out_valid) |-> $past(state_r == ST_DONE))
  // In mono mode the right output stays silent.
  `SGPM_ASSERT(a_mono_right_zero, (state_r == ST_PEAK && !stereo_r) |-> (or_r == '0))
  // Without a report the meter level reads as zero.
  `SGPM_ASSERT(a_level_needs_update, (out_valid && !out_data.meter_update) |-> (out_data.meter_level == '0))
  // Reset returns the sequencer to idle with the output register empty.
  `SGPM_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r))

endmodule

`default_nettype wire

/* design/sgpm_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module sgpm_cfg_regs (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [sgpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [sgpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output sgpm_pkg::cfg_t                 cfg
);
  import sgpm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and update the addressed field.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_GAIN:     cfg_nxt.target_gain     = cfg_wdata[COEFF_W-1:0];
        CFG_GAIN_ENABLE:     cfg_nxt.gain_enable     = cfg_wdata[0];
        CFG_SMOOTHING_COEFF: cfg_nxt.smoothing_coeff = cfg_wdata[COEFF_W-1:0];
        CFG_METER_FALLOFF:   cfg_nxt.meter_falloff   = cfg_wdata[COEFF_W-1:0];
        CFG_STEREO_MODE:     cfg_nxt.stereo_mode     = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_gain     <= TARGET_GAIN_RST;
      cfg_r.gain_enable     <= 1'b1;
      cfg_r.smoothing_coeff <= SMOOTHING_RST;
      cfg_r.meter_falloff   <= FALLOFF_RST;
      cfg_r.stereo_mode     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* design/sgpm_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module sgpm_mul (
  input  wire                                  clk,
  input  wire signed [sgpm_pkg::MUL_A_W-1:0]   mul_a,
  input  wire signed [sgpm_pkg::MUL_B_W-1:0]   mul_b,
  output logic signed [sgpm_pkg::MUL_P_W-1:0]  prod_r
);

  // Signed multiply with the product registered; one result per cycle.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sgpm_pkg::*;

  // Fixed-point constants used by the gain and meter predictor.
  localparam longint ONE_Q24 = 64'sd16777216;
  localparam longint GAIN_CEIL = (64'sd1 <<< 28) - 64'sd1;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;
  localparam longint unsigned FS_MAG = 64'd8388608;
  localparam longint unsigned UONE_Q24 = 64'd16777216;
  localparam int QUIET_DB = -30720;
  localparam int REPORT_STEP = 52;
  localparam logic [23:0] TARGET_MIN = 24'd104858;
  localparam logic [23:0] TARGET_MAX = 24'd10485760;
  localparam logic [23:0] Q24_FULL = 24'hFF_FFFF;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_FRAMES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the register file, as the predictor sees it.
  logic [23:0] sh_target;
  logic sh_enable;
  logic [23:0] sh_coeff;
  logic [23:0] sh_falloff;
  logic sh_stereo;

  // Predicted block state.
  longint gain_q424;
  longint unsigned peak_mag;
  int last_db;

  out_item_t expected_frames[$];
  int err_count = 0;
  int frames_sent = 0;
  int reg_writes = 0;
  int reports_seen = 0;
  int silence_reports = 0;

  smoothed_gain_peak_meter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rounds half up at 2^-24, flooring towards minus infinity.
  function automatic longint round_q24(input longint p);
    return (p + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic longint clip_sample(input longint v);
    if (v > SAMPLE_HI) return SAMPLE_HI;
    if (v < SAMPLE_LO) return SAMPLE_LO;
    return v;
  endfunction

  // Peak magnitude to 1/256 dB via exponent plus parabola log2.
  function automatic int peak_to_db(input longint unsigned p);
    int b;
    longint unsigned m;
    longint unsigned f;
    longint unsigned g;
    longint l2;
    longint num;
    longint den;
    longint db;
    if (p * 64'd1000000 <= FS_MAG) return QUIET_DB;
    b = 0;
    while (b < 63 && (p >> (b + 1)) != 0) b++;
    m = (b > 24) ? (p >> (b - 24)) : (p << (24 - b));
    f = m - UONE_Q24;
    g = (f * (4 * UONE_Q24 - f) + 3 * (UONE_Q24 >> 1)) / (3 * UONE_Q24);
    l2 = longint'(b - 23) * ONE_Q24 + longint'(g);
    num = l2 * 320;
    den = 64'sd53 * 64'sd65536;
    if (num >= 0) db = (num + den / 2) / den;
    else db = -((-num + den / 2) / den);
    if (db > 32767) db = 32767;
    if (db < -32768) db = -32768;
    return int'(db);
  endfunction

  // Advances the predicted state by one frame and returns the expected result.
  function automatic out_item_t gain_meter_step(input in_item_t frame);
    out_item_t res;
    longint target;
    longint ol;
    longint orr;
    longint unsigned mag;
    int db;
    int diff;
    res = '0;
    orr = 0;
    target = sh_enable ? (longint'(sh_target) <<< 4) : ONE_Q24;
    gain_q424 = gain_q424 + round_q24(longint'(sh_coeff) * (target - gain_q424));
    if (gain_q424 < 0) gain_q424 = 0;
    if (gain_q424 > GAIN_CEIL) gain_q424 = GAIN_CEIL;

    ol = clip_sample(round_q24(longint'(frame.sample_left) * gain_q424));
    mag = (ol < 0) ? longint'(-ol) : ol;
    if (mag > peak_mag) peak_mag = mag;
    if (sh_stereo) begin
      orr = clip_sample(round_q24(longint'(frame.sample_right) * gain_q424));
      mag = (orr < 0) ? longint'(-orr) : orr;
      if (mag > peak_mag) peak_mag = mag;
    end

    // Meter report on block end, then decay of the held peak.
    if (frame.block_end) begin
      db = peak_to_db(peak_mag);
      diff = (db > last_db) ? db - last_db : last_db - db;
      if (db == QUIET_DB && last_db != QUIET_DB) begin
        res.meter_update = 1'b1;
        res.meter_level = '0;
        last_db = db;
      end else if (diff >= REPORT_STEP) begin
        res.meter_update = 1'b1;
        res.meter_level = (peak_mag > 64'hFF_FFFF) ? Q24_FULL : peak_mag[23:0];
        last_db = db;
      end
      peak_mag = (peak_mag * longint'(sh_falloff)) >> 24;
    end

    res.out_left = ol[23:0];
    res.out_right = orr[23:0];
    return res;
  endfunction

  function automatic in_item_t make_frame(input int l, input int r, input bit e);
    in_item_t f;
    f.sample_left = 24'(l);
    f.sample_right = 24'(r);
    f.block_end = e;
    return f;
  endfunction

  // Sample for a block: shift < 0 means a quiet block.
  function automatic logic signed [23:0] block_sample(input int shift);
    logic signed [23:0] raw;
    raw = 24'($urandom);
    if (shift < 0) return ($urandom_range(0, 1) == 0) ? 24'sd0 : raw >>> 21;
    if ($urandom_range(0, 15) == 0) return ($urandom_range(0, 1) == 0) ? 24'sh7F_FFFF : 24'sh80_0000;
    return raw >>> shift;
  endfunction

  // Sends one request and records its expected result once it is taken.
  task automatic send_frame(input in_item_t frame);
    in_valid <= 1'b1;
    in_data <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_frames.push_back(gain_meter_step(frame));
    frames_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Lets every outstanding result come back so the block is idle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET_GAIN: sh_target = val;
      CFG_GAIN_ENABLE: sh_enable = val[0];
      CFG_SMOOTHING_COEFF: sh_coeff = val;
      CFG_METER_FALLOFF: sh_falloff = val;
      CFG_STEREO_MODE: sh_stereo = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Default settings: gain ramps from zero, silence is reported first.
  task automatic test_reset_defaults();
    send_frame(make_frame(0, 0, 1'b1));
    send_frame(make_frame(0, 0, 1'b1));
    send_frame(make_frame(8388607, -8388608, 1'b0));
    send_frame(make_frame(-1, 1, 1'b1));
    finish_phase();
  endtask

  // Largest gain with an instant step: outputs saturate on both rails.
  task automatic test_full_scale_gain();
    write_reg(CFG_SMOOTHING_COEFF, Q24_FULL);
    write_reg(CFG_TARGET_GAIN, TARGET_MAX);
    send_frame(make_frame(8388607, -8388608, 1'b0));
    send_frame(make_frame(4000000, -4000000, 1'b1));
    send_frame(make_frame(1, -1, 1'b1));
    send_frame(make_frame(-8388608, 8388607, 1'b1));
    finish_phase();
  endtask

  // Smallest target, then unity while gain is switched off.
  task automatic test_min_gain_and_bypass();
    write_reg(CFG_TARGET_GAIN, TARGET_MIN);
    send_frame(make_frame(8388607, -8388608, 1'b1));
    send_frame(make_frame(-5, 5, 1'b1));
    finish_phase();
    write_reg(CFG_GAIN_ENABLE, 24'd0);
    send_frame(make_frame(12345, -12345, 1'b1));
    send_frame(make_frame(-8388608, 8388607, 1'b0));
    finish_phase();
  endtask

  // A zero coefficient holds the gain where it stands.
  task automatic test_frozen_gain();
    write_reg(CFG_GAIN_ENABLE, 24'd1);
    write_reg(CFG_SMOOTHING_COEFF, 24'd0);
    send_frame(make_frame(654321, -654321, 1'b0));
    send_frame(make_frame(-2, 3, 1'b1));
    finish_phase();
  endtask

  // Mono: the right channel is ignored and reads back as zero.
  task automatic test_mono();
    write_reg(CFG_SMOOTHING_COEFF, Q24_FULL);
    write_reg(CFG_STEREO_MODE, 24'd0);
    send_frame(make_frame(100, 8388607, 1'b1));
    send_frame(make_frame(-8388608, -8388608, 1'b1));
    finish_phase();
  endtask

  // A zero falloff drops the peak to silence at once; full falloff keeps it.
  task automatic test_falloff_extremes();
    write_reg(CFG_STEREO_MODE, 24'd1);
    write_reg(CFG_METER_FALLOFF, 24'd0);
    send_frame(make_frame(5000, 0, 1'b1));
    send_frame(make_frame(0, 0, 1'b1));
    finish_phase();
    write_reg(CFG_METER_FALLOFF, Q24_FULL);
    send_frame(make_frame(8388607, 0, 1'b1));
    send_frame(make_frame(0, 0, 1'b1));
    send_frame(make_frame(0, 0, 1'b1));
    finish_phase();
  endtask

  // Picks a setting per phase, then streams blocks of random frames.
  task automatic test_random_blocks(input int phase, input int n_frames);
    in_item_t f;
    logic [23:0] val;
    int block_left;
    int block_shift;
    int burst_left;
    block_left = 0;
    block_shift = 0;
    burst_left = $urandom_range(1, 20);
    case (phase % 4)
      0: val = TARGET_MAX;
      1: val = TARGET_MIN;
      default: val = 24'($urandom_range(TARGET_MIN, TARGET_MAX));
    endcase
    write_reg(CFG_TARGET_GAIN, val);
    write_reg(CFG_GAIN_ENABLE, 24'($urandom_range(0, 3) != 0));
    case ($urandom_range(0, 4))
      0: val = Q24_FULL;
      1: val = 24'd0;
      2: val = 24'($urandom_range(0, 65535));
      default: val = 24'($urandom_range(0, 24'hFF_FFFF));
    endcase
    write_reg(CFG_SMOOTHING_COEFF, val);
    case ($urandom_range(0, 3))
      0: val = 24'd0;
      1: val = Q24_FULL;
      2: val = 24'($urandom_range(0, 24'h7F_FFFF));
      default: val = 24'($urandom_range(24'h80_0000, 24'hFF_FFFF));
    endcase
    write_reg(CFG_METER_FALLOFF, val);
    write_reg(CFG_STEREO_MODE, 24'($urandom_range(0, 2) != 0));

    for (int i = 0; i < n_frames; i++) begin
      if (block_left == 0) begin
        block_left = $urandom_range(1, 16);
        block_shift = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 23);
      end
      f.sample_left = block_sample(block_shift);
      f.sample_right = block_sample(block_shift);
      f.block_end = (block_left == 1);
      block_left--;
      send_frame(f);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
    end
    finish_phase();
  endtask

  // Receiver: runs of steady readiness, long stalls and random toggling.
  initial begin : rx_stall_pattern
    int run;
    int mode;
    forever begin
      run = $urandom_range(1, 24);
      mode = $urandom_range(0, 3);
      repeat (run) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'b0;
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Compares each taken result with the oldest expectation.
  always @(posedge clk) begin : result_checker
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("Result taken with no request outstanding");
        err_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_data.out_left !== want.out_left) begin
          $error("out_left: expected %0d, got %0d", want.out_left, out_data.out_left);
          err_count++;
        end
        if (out_data.out_right !== want.out_right) begin
          $error("out_right: expected %0d, got %0d", want.out_right, out_data.out_right);
          err_count++;
        end
        if (out_data.meter_update !== want.meter_update) begin
          $error("meter_update: expected %0d, got %0d", want.meter_update,
                 out_data.meter_update);
          err_count++;
        end
        if (out_data.meter_level !== want.meter_level) begin
          $error("meter_level: expected %0d, got %0d", want.meter_level,
                 out_data.meter_level);
          err_count++;
        end
        if (want.meter_update) begin
          reports_seen++;
          if (want.meter_level == 0) silence_reports++;
        end
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_sequence
    sh_target = TARGET_GAIN_RST;
    sh_enable = 1'b1;
    sh_coeff = SMOOTHING_RST;
    sh_falloff = FALLOFF_RST;
    sh_stereo = 1'b1;
    gain_q424 = 0;
    peak_mag = 0;
    last_db = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_scale_gain();
    test_min_gain_and_bypass();
    test_frozen_gain();
    test_mono();
    test_falloff_extremes();
    for (int p = 0; p < RANDOM_PHASES; p++) test_random_blocks(p, PHASE_FRAMES);

    // Allow for the longest block end conversion before closing.
    repeat (64) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $error("%0d expected results never arrived", expected_frames.size());
      err_count++;
    end
    $display("Sent %0d frames across %0d register writes.", frames_sent, reg_writes);
    $display("Checked %0d meter reports, %0d of them silence.", reports_seen,
             silence_reports);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
